// File: rtl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg
// shared constants, command codes and controller/datapath link types for the
// complementary tone pwm unit
// ----------------------------------------------------------------------------
package ctp_pkg;

  // base clock and timer width
  localparam int CLOCK_HZ   = 16000000;
  localparam int COUNT_BITS = 16;

  // field widths
  localparam int FREQ_W  = 16;
  localparam int SHIFT_W = 4;
  localparam int DUTY_W  = 6;
  localparam int PER_W   = 16;
  localparam int PS_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // prescaler saturates at this shift
  localparam int PS_MAX_SHIFT = 9;

  // duty is given in percent
  localparam int PCT_DIV = 100;

  // period divider sizing, the register also holds the period-duty product
  localparam int CLK_W  = $clog2(CLOCK_HZ + 1);
  localparam int PROD_W = PER_W + DUTY_W;
  localparam int DIV_W  = (CLK_W > PROD_W) ? CLK_W : PROD_W;
  localparam int DVSR_W = FREQ_W + (2 ** SHIFT_W) - 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // percent divide as a reciprocal multiply, exact for every product below 2^PROD_W
  localparam int PCT_RECIP_SHIFT = 29;
  localparam int PCT_RECIP       = (2 ** PCT_RECIP_SHIFT + PCT_DIV - 1) / PCT_DIV;
  localparam int RECIP_W         = $clog2(PCT_RECIP + 1);
  localparam int PPROD_W         = PROD_W + RECIP_W;

  // compare width covers both the timer and the 16-bit compare points
  localparam int CMP_W = (COUNT_BITS > PER_W) ? COUNT_BITS : PER_W;

  // command codes
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_TONE_ON = 2'd1,
    CMD_TONE_OFF = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_code_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_FREQ     = 3'd0,
    REG_MAX_FREQ     = 3'd1,
    REG_LOW_LIMIT    = 3'd2,
    REG_LOW_SHIFT    = 3'd3,
    REG_NORMAL_SHIFT = 3'd4,
    REG_DUTY         = 3'd5,
    REG_SILENT       = 3'd6,
    REG_UNUSED       = 3'd7
  } cfg_reg_t;

  // controller to datapath commands
  typedef struct packed {
    logic step_cmd;     // run a single-step request and load the result
    logic tone_start;   // latch tone, load divider with the period division
    logic div_step;     // one restoring divider step
    logic period_load;  // saturate quotient into the period
    logic part_start;   // multiply period by duty into the divider register
    logic tone_apply;   // scale by the percent reciprocal, set compares, start timer
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_range;   // requested frequency inside min..max
    logic div_last;   // current divider step is the final one
    logic out_free;   // result register can take a new result this cycle
  } dp_status_t;

endpackage

// File: rtl/ctp_ctrl.sv
// ----------------------------------------------------------------------------
// ctp_ctrl
// sequencer for the tone generator: takes requests, walks the serial divider
// through the period division, and hands results to the datapath
// ----------------------------------------------------------------------------
module ctp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  ctp_pkg::dp_status_t status,
  output ctp_pkg::dp_cmd_t    dp_cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_PERIOD,
    S_PERIOD,
    S_MUL,
    S_APPLY
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  // requests are taken only while no tone on is being worked out and with room for the result
  assign in_stall = !((state == S_IDLE) && status.out_free);
  assign take     = in_valid && !in_stall;

  // command decode and next state
  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    case (state)
      S_IDLE: begin
        if (take) begin
          if ((cmd == ctp_pkg::CMD_TONE_ON) && status.in_range) begin
            dp_cmd.tone_start = 1'b1;
            state_next        = S_DIV_PERIOD;
          end else begin
            dp_cmd.step_cmd = 1'b1;
          end
        end
      end
      S_DIV_PERIOD: begin
        dp_cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_PERIOD;
        end
      end
      S_PERIOD: begin
        dp_cmd.period_load = 1'b1;
        state_next         = S_MUL;
      end
      S_MUL: begin
        dp_cmd.part_start = 1'b1;
        state_next        = S_APPLY;
      end
      S_APPLY: begin
        if (status.out_free) begin
          dp_cmd.tone_apply = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/ctp_datapath.sv
// ----------------------------------------------------------------------------
// ctp_datapath
// configuration registers, scaled timer with compare toggles, serial period
// divider with a reciprocal duty scale, and the result register
// ----------------------------------------------------------------------------
module ctp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_valid,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ctp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // request payload
  input  logic [1:0]                          cmd,
  input  logic [ctp_pkg::FREQ_W-1:0]          freq_hz,
  // controller link
  input  ctp_pkg::dp_cmd_t                    dp_cmd,
  output ctp_pkg::dp_status_t                 status,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                pin_a,
  output logic                                pin_b,
  output logic                                driver_enable,
  output logic                                accepted
);

  // configuration
  logic [ctp_pkg::FREQ_W-1:0]  min_freq;
  logic [ctp_pkg::FREQ_W-1:0]  max_freq;
  logic [ctp_pkg::FREQ_W-1:0]  low_freq_limit;
  logic [ctp_pkg::SHIFT_W-1:0] low_prescale_shift;
  logic [ctp_pkg::SHIFT_W-1:0] normal_prescale_shift;
  logic [ctp_pkg::DUTY_W-1:0]  duty_percent;
  logic                        silent;

  // tone state
  logic                          running;
  logic [ctp_pkg::SHIFT_W-1:0]   prescale_shift;
  logic [ctp_pkg::PS_W-1:0]      prescale_count;
  logic [ctp_pkg::COUNT_BITS-1:0] timer_count;
  logic [ctp_pkg::PER_W-1:0]     period_value;
  logic [ctp_pkg::PER_W-1:0]     compare_a;
  logic [ctp_pkg::PER_W-1:0]     compare_b;
  logic                          level_a;
  logic                          level_b;
  logic                          wake_level;

  logic                          running_next;
  logic [ctp_pkg::PS_W-1:0]      prescale_count_next;
  logic [ctp_pkg::COUNT_BITS-1:0] timer_count_next;
  logic                          level_a_next;
  logic                          level_b_next;
  logic                          wake_level_next;

  // divider
  logic [ctp_pkg::DIV_W-1:0]  div_quo;
  logic [ctp_pkg::DVSR_W-1:0] div_rem;
  logic [ctp_pkg::DVSR_W-1:0] div_dvsr;
  logic [ctp_pkg::DCNT_W-1:0] div_cnt;
  logic [ctp_pkg::DVSR_W:0]   rem_shift;
  logic [ctp_pkg::DVSR_W:0]   rem_diff;
  logic                       quo_bit;

  // tick helpers
  logic [ctp_pkg::SHIFT_W-1:0]    shift_sat;
  logic [ctp_pkg::PS_W-1:0]       ps_limit;
  logic [ctp_pkg::COUNT_BITS-1:0] count_inc;
  logic [ctp_pkg::CMP_W-1:0]      count_cmp;
  logic [ctp_pkg::PER_W-1:0]      end_a;
  logic                           hit_a;
  logic                           hit_b;
  logic                           hit_end;

  // tone-on helpers
  logic                          low_tone;
  logic [ctp_pkg::PER_W-1:0]     period_sat;
  logic [ctp_pkg::PPROD_W-1:0]   part_prod;
  logic [ctp_pkg::PER_W-1:0]     part;
  logic                          out_free;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_freq              <= ctp_pkg::FREQ_W'(20);
      max_freq              <= ctp_pkg::FREQ_W'(20000);
      low_freq_limit        <= ctp_pkg::FREQ_W'(250);
      low_prescale_shift    <= ctp_pkg::SHIFT_W'(4);
      normal_prescale_shift <= '0;
      duty_percent          <= ctp_pkg::DUTY_W'(50);
      silent                <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ctp_pkg::REG_MIN_FREQ:     min_freq <= cfg_data;
        ctp_pkg::REG_MAX_FREQ:     max_freq <= cfg_data;
        ctp_pkg::REG_LOW_LIMIT:    low_freq_limit <= cfg_data;
        ctp_pkg::REG_LOW_SHIFT:    low_prescale_shift <= cfg_data[ctp_pkg::SHIFT_W-1:0];
        ctp_pkg::REG_NORMAL_SHIFT: normal_prescale_shift <= cfg_data[ctp_pkg::SHIFT_W-1:0];
        ctp_pkg::REG_DUTY:         duty_percent <= cfg_data[ctp_pkg::DUTY_W-1:0];
        ctp_pkg::REG_SILENT:       silent <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // range check and tone class of the incoming request
  assign low_tone        = freq_hz < low_freq_limit;
  assign status.in_range = (freq_hz >= min_freq) && (freq_hz <= max_freq);

  // divider step: shift in the next dividend bit, subtract when it fits
  assign rem_shift = {div_rem, div_quo[ctp_pkg::DIV_W-1]};
  assign rem_diff  = rem_shift - {1'b0, div_dvsr};
  assign quo_bit   = rem_shift >= {1'b0, div_dvsr};
  assign status.div_last = div_cnt == ctp_pkg::DCNT_W'(ctp_pkg::DIV_W - 1);

  // zero divisor leaves an all-ones quotient, which saturates like a long period
  assign period_sat = (|div_quo[ctp_pkg::DIV_W-1:ctp_pkg::PER_W]) ?
                      {ctp_pkg::PER_W{1'b1}} : div_quo[ctp_pkg::PER_W-1:0];

  // duty point: period-duty product divided by 100 through its reciprocal
  assign part_prod = ctp_pkg::PPROD_W'(div_quo[ctp_pkg::PROD_W-1:0]) *
                     ctp_pkg::PPROD_W'(ctp_pkg::PCT_RECIP);
  assign part      = part_prod[ctp_pkg::PCT_RECIP_SHIFT +: ctp_pkg::PER_W];

  // prescaler limit and timer compare
  assign shift_sat = (prescale_shift > ctp_pkg::SHIFT_W'(ctp_pkg::PS_MAX_SHIFT)) ?
                     ctp_pkg::SHIFT_W'(ctp_pkg::PS_MAX_SHIFT) : prescale_shift;
  assign ps_limit  = (ctp_pkg::PS_W'(1) << shift_sat) - ctp_pkg::PS_W'(1);
  assign count_inc = timer_count + ctp_pkg::COUNT_BITS'(1);
  assign count_cmp = ctp_pkg::CMP_W'(count_inc);
  assign end_a     = period_value - ctp_pkg::PER_W'(1);
  assign hit_end   = count_cmp == ctp_pkg::CMP_W'(period_value);
  assign hit_a     = (count_cmp == ctp_pkg::CMP_W'(compare_a)) ||
                     (count_cmp == ctp_pkg::CMP_W'(end_a));
  assign hit_b     = (count_cmp == ctp_pkg::CMP_W'(compare_b)) || hit_end;

  // next tone state for the single-step requests and for an applied tone
  always_comb begin
    running_next        = running;
    prescale_count_next = prescale_count;
    timer_count_next    = timer_count;
    level_a_next        = level_a;
    level_b_next        = level_b;
    wake_level_next     = wake_level;
    if (dp_cmd.step_cmd) begin
      case (cmd)
        ctp_pkg::CMD_TICK: begin
          if (running) begin
            if (prescale_count < ps_limit) begin
              prescale_count_next = prescale_count + ctp_pkg::PS_W'(1);
            end else begin
              prescale_count_next = '0;
              timer_count_next    = hit_end ? '0 : count_inc;
              if (hit_a) begin
                level_a_next = !level_a;
              end
              if (hit_b && !silent) begin
                level_b_next = !level_b;
              end
            end
          end
        end
        ctp_pkg::CMD_TONE_OFF: begin
          running_next        = 1'b0;
          prescale_count_next = '0;
          timer_count_next    = '0;
          level_a_next        = 1'b0;
          level_b_next        = 1'b0;
          wake_level_next     = 1'b0;
        end
        default: begin
          // rejected tone on and the unused code leave the state alone
        end
      endcase
    end else if (dp_cmd.tone_apply) begin
      running_next        = 1'b1;
      prescale_count_next = '0;
      timer_count_next    = '0;
      level_a_next        = 1'b0;
      level_b_next        = 1'b1;
      wake_level_next     = 1'b1;
    end
  end

  // tone state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      prescale_shift <= '0;
      prescale_count <= '0;
      timer_count    <= '0;
      period_value   <= '0;
      compare_a      <= '0;
      compare_b      <= '0;
      level_a        <= 1'b0;
      level_b        <= 1'b0;
      wake_level     <= 1'b0;
    end else begin
      running        <= running_next;
      prescale_count <= prescale_count_next;
      timer_count    <= timer_count_next;
      level_a        <= level_a_next;
      level_b        <= level_b_next;
      wake_level     <= wake_level_next;
      if (dp_cmd.tone_start) begin
        prescale_shift <= low_tone ? low_prescale_shift : normal_prescale_shift;
      end
      if (dp_cmd.period_load) begin
        period_value <= period_sat;
      end
      if (dp_cmd.tone_apply) begin
        compare_a <= period_value - part;
        compare_b <= part - ctp_pkg::PER_W'(1);
      end
    end
  end

  // serial period divider, its dividend register then holds the duty product
  always_ff @(posedge clk) begin
    if (dp_cmd.tone_start) begin
      div_quo  <= ctp_pkg::DIV_W'(ctp_pkg::CLOCK_HZ);
      div_rem  <= '0;
      div_cnt  <= '0;
      div_dvsr <= low_tone ? (ctp_pkg::DVSR_W'(freq_hz) << low_prescale_shift) :
                             ctp_pkg::DVSR_W'(freq_hz);
    end else if (dp_cmd.part_start) begin
      div_quo  <= ctp_pkg::DIV_W'(ctp_pkg::PROD_W'(period_value) *
                                  ctp_pkg::PROD_W'(duty_percent));
    end else if (dp_cmd.div_step) begin
      div_quo <= {div_quo[ctp_pkg::DIV_W-2:0], quo_bit};
      div_rem <= quo_bit ? rem_diff[ctp_pkg::DVSR_W-1:0] : rem_shift[ctp_pkg::DVSR_W-1:0];
      div_cnt <= div_cnt + ctp_pkg::DCNT_W'(1);
    end
  end

  // result register
  assign out_free        = !out_valid || !out_stall;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.step_cmd || dp_cmd.tone_apply) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.step_cmd || dp_cmd.tone_apply) begin
      pin_a         <= level_a_next;
      pin_b         <= level_b_next;
      driver_enable <= wake_level_next;
      accepted      <= dp_cmd.tone_apply;
    end
  end

endmodule

// File: rtl/complementary_tone_pwm_unit.sv
// ----------------------------------------------------------------------------
// complementary_tone_pwm_unit
// tone generator driving two complementary bridge pins from a prescaled timer
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        sink       in_valid / in_stall   cmd, freq_hz
// out       source     out_valid / out_stall pin_a, pin_b, driver_enable, accepted
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// tick, tone off, rejected tone on: a new request each cycle while the result side keeps up
// accepted tone on: the restoring divider forms the period, then the period is
//   loaded, scaled by duty and applied; the duty point is one reciprocal multiply
// synchronous reset clears the tone state and restores register defaults
// a stalled result holds and stalls the request side until it drains
// ----------------------------------------------------------------------------
module complementary_tone_pwm_unit (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic [ctp_pkg::FREQ_W-1:0]     freq_hz,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           pin_a,
  output logic                           pin_b,
  output logic                           driver_enable,
  output logic                           accepted,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctp_pkg::CFG_DATA_W-1:0] cfg_data
);

  ctp_pkg::dp_cmd_t    dp_cmd;
  ctp_pkg::dp_status_t status;

  // register writes are never held off
  assign cfg_ready = 1'b1;

  // sequencer
  ctp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status),
    .dp_cmd   (dp_cmd)
  );

  // timer, divider and result register
  ctp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .freq_hz       (freq_hz),
    .dp_cmd        (dp_cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pin_a         (pin_a),
    .pin_b         (pin_b),
    .driver_enable (driver_enable),
    .accepted      (accepted)
  );

endmodule

// File: rtl/ctp_checker.sv
// ----------------------------------------------------------------------------
// ctp_checker
// port-level checks for the complementary tone pwm unit, bound to the top
// ----------------------------------------------------------------------------
module ctp_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic pin_a,
  input logic pin_b,
  input logic driver_enable,
  input logic accepted
);

  // an applied tone starts with the first pin low, the second high, driver on
  a_tone_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (!pin_a && pin_b && driver_enable))
    else $error("applied tone shows wrong starting levels");

  // with the driver asleep both pins are low
  a_sleep_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !driver_enable) |-> (!pin_a && !pin_b))
    else $error("pin high while driver is asleep");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(pin_a) && $stable(pin_b) &&
       $stable(driver_enable) && $stable(accepted)))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind complementary_tone_pwm_unit ctp_checker u_ctp_checker (.*);

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the complementary tone pwm unit against a cycle-free model of its
// tone timer: a table of directed requests, then tone sequences with random
// content under several register settings, with random idling on both sides
// and one long result hold that backs the block up into its request side
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 6;

  // levels reported by one result, pin_a in the top bit
  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic drv_en;
    logic acc;
  } tone_levels_t;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

  // one line of the directed table: a request repeated reps times, or a register write
  typedef struct packed {
    row_kind_t          kind;
    ctp_pkg::cmd_code_t op;
    ctp_pkg::cfg_reg_t  reg_sel;
    logic [15:0]        val;
    logic [3:0]         reps;
    bit                 typed;
    tone_levels_t       want;
  } dir_row_t;

  localparam int NUM_ROWS = 30;
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // stopped block: nothing moves, unused code ignored, out-of-range tones refused
    '{ROW_ITEM, ctp_pkg::CMD_TICK, ctp_pkg::REG_UNUSED, 16'hFFFF, 4'd1, 1'b1, 4'b0000},
    '{ROW_ITEM, ctp_pkg::CMD_NONE, ctp_pkg::REG_UNUSED, 16'hAAAA, 4'd1, 1'b1, 4'b0000},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_OFF, ctp_pkg::REG_UNUSED, 16'h5555, 4'd1, 1'b1, 4'b0000},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd0, 4'd1, 1'b1, 4'b0000},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd19, 4'd1, 1'b1, 4'b0000},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd20001, 4'd1, 1'b1, 4'b0000},
    // band edges, low and normal path
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd20, 4'd1, 1'b1, 4'b0111},
    '{ROW_ITEM, ctp_pkg::CMD_TICK, ctp_pkg::REG_UNUSED, 16'h0000, 4'd2, 1'b1, 4'b0110},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd20000, 4'd1, 1'b1, 4'b0111},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd65535, 4'd1, 1'b1, 4'b0110},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_OFF, ctp_pkg::REG_UNUSED, 16'd0, 4'd1, 1'b1, 4'b0000},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd249, 4'd1, 1'b1, 4'b0111},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd250, 4'd1, 1'b1, 4'b0111},
    // widest band, smallest duty
    '{ROW_WRITE, ctp_pkg::CMD_NONE, ctp_pkg::REG_LOW_LIMIT, 16'd1, 4'd0, 1'b0, 4'b0000},
    '{ROW_WRITE, ctp_pkg::CMD_NONE, ctp_pkg::REG_MIN_FREQ, 16'd1, 4'd0, 1'b0, 4'b0000},
    '{ROW_WRITE, ctp_pkg::CMD_NONE, ctp_pkg::REG_MAX_FREQ, 16'd65535, 4'd0, 1'b0, 4'b0000},
    '{ROW_WRITE, ctp_pkg::CMD_NONE, ctp_pkg::REG_DUTY, 16'd1, 4'd0, 1'b0, 4'b0000},
    // period too long saturates, then the shortest period
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd1, 4'd1, 1'b1, 4'b0111},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd65535, 4'd1, 1'b1, 4'b0111},
    '{ROW_ITEM, ctp_pkg::CMD_TICK, ctp_pkg::REG_UNUSED, 16'd1234, 4'd3, 1'b0, 4'b0000},
    '{ROW_WRITE, ctp_pkg::CMD_NONE, ctp_pkg::REG_NORMAL_SHIFT, 16'd9, 4'd0, 1'b0, 4'b0000},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd65535, 4'd1, 1'b1, 4'b0111},
    '{ROW_ITEM, ctp_pkg::CMD_TICK, ctp_pkg::REG_UNUSED, 16'hF0F0, 4'd2, 1'b0, 4'b0000},
    // low shift above nine
    '{ROW_WRITE, ctp_pkg::CMD_NONE, ctp_pkg::REG_LOW_SHIFT, 16'd15, 4'd0, 1'b0, 4'b0000},
    '{ROW_WRITE, ctp_pkg::CMD_NONE, ctp_pkg::REG_LOW_LIMIT, 16'd65535, 4'd0, 1'b0, 4'b0000},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_ON, ctp_pkg::REG_UNUSED, 16'd100, 4'd1, 1'b1, 4'b0111},
    '{ROW_ITEM, ctp_pkg::CMD_TICK, ctp_pkg::REG_UNUSED, 16'h0F0F, 4'd2, 1'b0, 4'b0000},
    // silent switched on while a tone runs
    '{ROW_WRITE, ctp_pkg::CMD_NONE, ctp_pkg::REG_SILENT, 16'd1, 4'd0, 1'b0, 4'b0000},
    '{ROW_ITEM, ctp_pkg::CMD_TICK, ctp_pkg::REG_UNUSED, 16'd7, 4'd2, 1'b0, 4'b0000},
    '{ROW_ITEM, ctp_pkg::CMD_TONE_OFF, ctp_pkg::REG_UNUSED, 16'd0, 4'd1, 1'b1, 4'b0000}
  };

  // register settings of the random phases, in register index order;
  // the last phase draws its own
  localparam logic [15:0] PHASE_REGS [5][7] = '{
    '{16'd20,    16'd65535, 16'd65535, 16'd4,  16'd0, 16'd50, 16'd0},
    '{16'd1,     16'd65535, 16'd1,     16'd0,  16'd0, 16'd1,  16'd0},
    '{16'd1000,  16'd65535, 16'd40000, 16'd9,  16'd2, 16'd25, 16'd1},
    '{16'd1,     16'd65535, 16'd65535, 16'd15, 16'd9, 16'd50, 16'd0},
    '{16'd65535, 16'd65535, 16'd1,     16'd0,  16'd0, 16'd50, 16'd0}
  };

  // dut connections, every input known from time zero
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  logic [1:0]                     cmd       = ctp_pkg::CMD_NONE;
  logic [ctp_pkg::FREQ_W-1:0]     freq_hz   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           pin_a;
  logic                           pin_b;
  logic                           driver_enable;
  logic                           accepted;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ctp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ctp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  complementary_tone_pwm_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .freq_hz       (freq_hz),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pin_a         (pin_a),
    .pin_b         (pin_b),
    .driver_enable (driver_enable),
    .accepted      (accepted),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // tone model registers
  logic [15:0] min_hz, max_hz, low_band_hz;
  logic [3:0]  low_shift, norm_shift;
  logic [5:0]  duty_pct;
  logic        quiet;

  // tone model state
  logic        tone_live;
  logic [3:0]  div_shift;
  logic [8:0]  div_count;
  logic [15:0] tmr_count, tone_period, edge_a, edge_b;
  logic        lvl_a, lvl_b, wake;

  tone_levels_t levels_due [$];

  // directed rows may carry their own expected levels
  bit           row_typed = 1'b0;
  tone_levels_t row_want  = '0;

  int mismatches   = 0;
  int requests     = 0;
  int tones_begun  = 0;
  int tones_denied = 0;
  int pin_toggles  = 0;
  int reg_writes   = 0;

  int send_idle_pct = 23;
  int recv_idle_pct = 50;
  bit hold_ask      = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  logic [15:0] reg_plan [7];

  // advance the tone model by one request and return the levels it shows
  function automatic tone_levels_t model_step(ctp_pkg::cmd_code_t op, logic [15:0] f);
    logic                ok;
    logic                low;
    logic [3:0]          s;
    logic [8:0]          lim;
    logic [15:0]         c;
    longint unsigned     dvsr, quo, part;
    ok = 1'b0;
    requests++;
    case (op)
      ctp_pkg::CMD_TICK: begin
        if (tone_live) begin
          s   = (div_shift > 4'(ctp_pkg::PS_MAX_SHIFT)) ? 4'(ctp_pkg::PS_MAX_SHIFT) :
                                                          div_shift;
          lim = 9'((1 << s) - 1);
          if (div_count < lim) begin
            div_count = div_count + 9'd1;
          end else begin
            div_count = '0;
            c = tmr_count + 16'd1;
            tmr_count = c;
            if (c == edge_a || c == tone_period - 16'd1) begin
              lvl_a = ~lvl_a;
              pin_toggles++;
            end
            if ((c == edge_b || c == tone_period) && !quiet) begin
              lvl_b = ~lvl_b;
              pin_toggles++;
            end
            if (c == tone_period) tmr_count = '0;
          end
        end
      end
      ctp_pkg::CMD_TONE_ON: begin
        if (f >= min_hz && f <= max_hz) begin
          low       = (f < low_band_hz);
          div_shift = low ? low_shift : norm_shift;
          dvsr      = low ? (64'(f) << low_shift) : 64'(f);
          // zero divisor and overlong periods both land on the top value
          quo = (dvsr == 0) ? 64'hFFFF : 64'(ctp_pkg::CLOCK_HZ) / dvsr;
          if (quo > 64'hFFFF) quo = 64'hFFFF;
          tone_period = quo[15:0];
          part        = 64'(tone_period) * 64'(duty_pct) / 64'(ctp_pkg::PCT_DIV);
          edge_a      = 16'(64'(tone_period) - part);
          edge_b      = 16'(part - 64'd1);
          tone_live   = 1'b1;
          div_count   = '0;
          tmr_count   = '0;
          lvl_a       = 1'b0;
          lvl_b       = 1'b1;
          wake        = 1'b1;
          ok          = 1'b1;
          tones_begun++;
        end else begin
          tones_denied++;
        end
      end
      ctp_pkg::CMD_TONE_OFF: begin
        tone_live = 1'b0;
        div_count = '0;
        tmr_count = '0;
        lvl_a     = 1'b0;
        lvl_b     = 1'b0;
        wake      = 1'b0;
      end
      default: ;
    endcase
    return {lvl_a, lvl_b, wake, ok};
  endfunction

  // model reset values
  initial begin
    min_hz      = 16'd20;
    max_hz      = 16'd20000;
    low_band_hz = 16'd250;
    low_shift   = 4'd4;
    norm_shift  = 4'd0;
    duty_pct    = 6'd50;
    quiet       = 1'b0;
    tone_live   = 1'b0;
    div_shift   = '0;
    div_count   = '0;
    tmr_count   = '0;
    tone_period = '0;
    edge_a      = '0;
    edge_b      = '0;
    lvl_a       = 1'b0;
    lvl_b       = 1'b0;
    wake        = 1'b0;
  end

  // request, result and register traffic seen at the rising edge
  always @(posedge clk) begin
    tone_levels_t due, seen;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        due = model_step(ctp_pkg::cmd_code_t'(cmd), freq_hz);
        levels_due.push_back(row_typed ? row_want : due);
      end
      if (out_valid && !out_stall) begin
        seen = {pin_a, pin_b, driver_enable, accepted};
        if (levels_due.size() == 0) begin
          $display("%0t ns: result %b with no request pending", $time, seen);
          mismatches++;
        end else begin
          due = levels_due.pop_front();
          if (due.pin_a !== seen.pin_a) begin
            $display("%0t ns: pin_a expected %b, got %b", $time, due.pin_a, seen.pin_a);
            mismatches++;
          end
          if (due.pin_b !== seen.pin_b) begin
            $display("%0t ns: pin_b expected %b, got %b", $time, due.pin_b, seen.pin_b);
            mismatches++;
          end
          if (due.drv_en !== seen.drv_en) begin
            $display("%0t ns: driver_enable expected %b, got %b", $time, due.drv_en,
                     seen.drv_en);
            mismatches++;
          end
          if (due.acc !== seen.acc) begin
            $display("%0t ns: accepted expected %b, got %b", $time, due.acc, seen.acc);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (ctp_pkg::cfg_reg_t'(cfg_index))
          ctp_pkg::REG_MIN_FREQ:     min_hz      = cfg_data;
          ctp_pkg::REG_MAX_FREQ:     max_hz      = cfg_data;
          ctp_pkg::REG_LOW_LIMIT:    low_band_hz = cfg_data;
          ctp_pkg::REG_LOW_SHIFT:    low_shift   = cfg_data[3:0];
          ctp_pkg::REG_NORMAL_SHIFT: norm_shift  = cfg_data[3:0];
          ctp_pkg::REG_DUTY:         duty_pct    = cfg_data[5:0];
          ctp_pkg::REG_SILENT:       quiet       = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // result side: random stalls, or one long hold when asked
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_ask  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results still due", $time,
               STALL_LIMIT, levels_due.size());
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request, entered and left at a falling edge
  task automatic send_request(ctp_pkg::cmd_code_t op, logic [15:0] f);
    int gap = 0;
    while (gap < 20 && $urandom_range(99, 0) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    freq_hz  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering requests and wait for every result
  task automatic drain;
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(ctp_pkg::cfg_reg_t r, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // in-band frequency, near the top of the band for short periods
  function automatic logic [15:0] pick_tone(bit near_top);
    int span;
    span = int'(max_hz) - int'(min_hz);
    if (!near_top) return 16'($urandom_range(max_hz, min_hz));
    if (span > 12000) span = 12000;
    return 16'(int'(max_hz) - int'($urandom_range(span, 0)));
  endfunction

  function automatic logic [15:0] pick_reject();
    if (max_hz == 16'hFFFF || $urandom_range(1, 0) == 0) begin
      return 16'($urandom_range(int'(min_hz) - 1, 0));
    end
    return 16'($urandom_range(16'hFFFF, int'(max_hz) + 1));
  endfunction

  // mostly tone sequences followed by tick runs, with refusals, stops and noise
  task automatic run_mix(int goal);
    int done = 0;
    int pick;
    int run;
    while (done < goal) begin
      pick = $urandom_range(99, 0);
      if (pick < 40) begin
        send_request(ctp_pkg::CMD_TONE_ON, pick_tone(1'b1));
        run = $urandom_range(350, 20);
        if (run > goal - done - 1) run = goal - done - 1;
        repeat (run) send_request(ctp_pkg::CMD_TICK, 16'($urandom));
        done += run + 1;
      end else if (pick < 55) begin
        send_request(ctp_pkg::CMD_TONE_ON, pick_tone(1'b0));
        done++;
      end else if (pick < 65) begin
        send_request(ctp_pkg::CMD_TONE_ON, pick_reject());
        done++;
      end else if (pick < 72) begin
        send_request(ctp_pkg::CMD_TONE_OFF, 16'($urandom));
        done++;
      end else if (pick < 77) begin
        send_request(ctp_pkg::CMD_NONE, 16'($urandom));
        done++;
      end else begin
        run = $urandom_range(40, 1);
        if (run > goal - done) run = goal - done;
        repeat (run) send_request(ctp_pkg::CMD_TICK, 16'($urandom));
        done += run;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
        drain();
        write_reg(DIRECTED_ROWS[i].reg_sel, DIRECTED_ROWS[i].val);
      end else begin
        row_typed = DIRECTED_ROWS[i].typed;
        row_want  = DIRECTED_ROWS[i].want;
        repeat (DIRECTED_ROWS[i].reps) send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].val);
      end
    end
    row_typed = 1'b0;

    // random phases: idling shifts from sender-light to receiver-light to none
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 23; recv_idle_pct = 50; end
        1: begin send_idle_pct = 50; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph < 5) begin
        for (int r = 0; r < 7; r++) reg_plan[r] = PHASE_REGS[ph][r];
      end else begin
        reg_plan[0] = 16'($urandom_range(2000, 1));
        reg_plan[1] = 16'($urandom_range(65535, 30000));
        reg_plan[2] = 16'($urandom_range(65535, 1));
        reg_plan[3] = 16'($urandom_range(15, 0));
        reg_plan[4] = 16'($urandom_range(9, 0));
        reg_plan[5] = 16'($urandom_range(50, 1));
        reg_plan[6] = 16'($urandom_range(1, 0));
      end
      drain();
      for (int r = 0; r < 7; r++) write_reg(ctp_pkg::cfg_reg_t'(r), reg_plan[r]);
      // long result hold while requests keep coming
      if (ph == 4) hold_ask = 1'b1;
      run_mix(PHASE_ITEMS);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (levels_due.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, levels_due.size());
      mismatches++;
    end
    $display("covered %0d requests: %0d tones started, %0d refused, %0d pin toggles",
             requests, tones_begun, tones_denied, pin_toggles);
    $display("over %0d register writes in %0d random phases", reg_writes, NUM_PHASES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
